// File: design/tlsp_pkg.sv
`default_nettype none

package tlsp_pkg;

    // Hold counter limits
    localparam int unsigned COUNT_WIDTH_DEF = 8;
    localparam int unsigned HOLD_SAT        = 250;  // counter stops here
    localparam int unsigned HOLD_LATCH      = 220;  // value after a long press
    localparam int unsigned LONG_LIMIT      = 210;  // long press only below this
    localparam int unsigned SHORT_LIMIT     = 200;  // short release only below this

    // Configuration register map
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_COUNT  = 2'd3;

    localparam logic [7:0] LONG_PRESS_RST  = 8'd100;
    localparam logic [6:0] SHORT_MIN_RST   = 7'd2;
    localparam logic [3:0] MOTOR_COUNT_RST = 4'd9;
    localparam logic [1:0] HEAT_COUNT_RST  = 2'd3;

    typedef struct packed {
        logic [7:0] long_press_ticks;
        logic [6:0] short_min_ticks;
        logic [3:0] motor_mode_count;
        logic [1:0] heat_mode_count;
    } t_cfg;

    typedef struct packed {
        logic long_press;
        logic short_press;
    } t_key_evt;

endpackage

`default_nettype wire

// File: design/two_key_long_short_press_mode_control.sv
// Two-key long/short press mode control.
// Input channel (i_in_valid / o_in_ready) carries one scan request: scan tick,
// two active-low key levels and the charger-present pin. Output channel
// (o_out_valid / i_out_ready) returns one result per request: work, motor
// mode, heat enable and level, charging flag and three one-shot pulses.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 long press ticks, 1 short minimum ticks, 2 motor mode count,
// 3 heat mode count. Write only while no request is in flight.
// Flow: a request is captured in the input register, then evaluated and
// written to the result register once that slot is free or being drained.
// Throughput: one request per cycle while the receiver takes results, set by the
// single evaluation step between input and result registers.
// Reset (synchronous, active low) clears both hold counters, work, heating,
// motor mode, charging flag and pulses, sets heat level to 1 and loads the
// configuration defaults. When the receiver stalls, the result holds, the
// input register fills and o_in_ready drops until the result is taken.
`default_nettype none

module two_key_long_short_press_mode_control #(
    parameter int unsigned COUNT_WIDTH = tlsp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [tlsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tlsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic                             i_scan_tick,
    input  wire logic                             i_key1_level,
    input  wire logic                             i_key2_level,
    input  wire logic                             i_charger_present,
    // result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_working,
    output logic [3:0]                            o_motor_mode,
    output logic                                  o_motor_refresh,
    output logic                                  o_heating,
    output logic [1:0]                            o_heat_mode,
    output logic                                  o_heat_timer_clear,
    output logic                                  o_charging,
    output logic                                  o_timers_clear
);

    tlsp_pkg::t_cfg     cfg;
    tlsp_pkg::t_key_evt key1_evt;
    tlsp_pkg::t_key_evt key2_evt;

    // input register
    logic r_in_valid;
    logic r_in_tick;
    logic r_in_key1;
    logic r_in_key2;
    logic r_in_chg;

    // result register; the mode fields double as the block state
    logic       r_out_valid;
    logic       r_work;
    logic [3:0] r_motor;
    logic       r_refresh;
    logic       r_heat;
    logic [1:0] r_level;
    logic       r_hclr;
    logic       r_chg;
    logic       r_tclr;

    logic       n_work;
    logic [3:0] n_motor;
    logic       n_refresh;
    logic       n_heat;
    logic [1:0] n_level;
    logic       n_hclr;
    logic [2:0] level_inc;

    logic advance;
    logic in_accept;

    // Advance the held request when the result slot is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    tlsp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tlsp_key_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_key1 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_clear       (r_in_chg),
        .i_tick        (r_in_tick),
        .i_level       (r_in_key1),
        .i_long_ticks  (cfg.long_press_ticks),
        .i_short_ticks (cfg.short_min_ticks),
        .o_evt         (key1_evt)
    );

    tlsp_key_unit #(.COUNT_WIDTH(COUNT_WIDTH)) u_key2 (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_clear       (r_in_chg),
        .i_tick        (r_in_tick),
        .i_level       (r_in_key2),
        .i_long_ticks  (cfg.long_press_ticks),
        .i_short_ticks (cfg.short_min_ticks),
        .o_evt         (key2_evt)
    );

    assign level_inc = {1'b0, r_level} + 3'd1;

    // Mode update: key 1 first, then key 2 sees the heat state key 1 left.
    always_comb begin
        n_work    = r_work;
        n_motor   = r_motor;
        n_refresh = 1'b0;
        n_heat    = r_heat;
        n_level   = r_level;
        n_hclr    = 1'b0;
        if (r_in_chg) begin
            // charger forces everything off; heat level is kept
            n_work    = 1'b0;
            n_heat    = 1'b0;
            n_motor   = '0;
            n_refresh = 1'b1;
        end else begin
            if (key1_evt.long_press) begin
                if (r_work) begin
                    n_work  = 1'b0;
                    n_heat  = 1'b0;
                    n_motor = '0;
                end else begin
                    n_work  = 1'b1;
                    n_motor = 4'd1;
                end
                n_refresh = 1'b1;
            end else if (key1_evt.short_press && r_work) begin
                // step the motor pattern with wrap back to one
                n_motor   = (r_motor < cfg.motor_mode_count) ? r_motor + 4'd1 : 4'd1;
                n_refresh = 1'b1;
            end

            if (key2_evt.long_press) begin
                if (n_heat) begin
                    n_heat = 1'b0;
                end else begin
                    n_heat  = 1'b1;
                    n_level = 2'd1;
                end
                n_hclr = 1'b1;
            end else if (key2_evt.short_press && n_heat) begin
                n_level = (level_inc > {1'b0, cfg.heat_mode_count}) ? 2'd1 : level_inc[1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload of the input register needs no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_tick <= i_scan_tick;
            r_in_key1 <= i_key1_level;
            r_in_key2 <= i_key2_level;
            r_in_chg  <= i_charger_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_work      <= 1'b0;
            r_motor     <= '0;
            r_refresh   <= 1'b0;
            r_heat      <= 1'b0;
            r_level     <= 2'd1;
            r_hclr      <= 1'b0;
            r_chg       <= 1'b0;
            r_tclr      <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_work      <= n_work;
                r_motor     <= n_motor;
                r_refresh   <= n_refresh;
                r_heat      <= n_heat;
                r_level     <= n_level;
                r_hclr      <= n_hclr;
                r_chg       <= r_in_chg;
                r_tclr      <= r_in_chg;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_working          = r_work;
    assign o_motor_mode       = r_motor;
    assign o_motor_refresh    = r_refresh;
    assign o_heating          = r_heat;
    assign o_heat_mode        = r_level;
    assign o_heat_timer_clear = r_hclr;
    assign o_charging         = r_chg;
    assign o_timers_clear     = r_tclr;

    // work mode and a running motor pattern go together
    a_work_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_working == (o_motor_mode != 4'd0))
        else $error("work mode and motor pattern disagree");

    // heat level never leaves the range one and up
    a_level_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_heat_mode != 2'd0)
        else $error("heat level dropped to zero");

    // a charging result has everything off, no heat timer pulse and the timers clear pulse set
    a_charge_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_charging |->
            !o_working && !o_heating && !o_heat_timer_clear && o_timers_clear)
        else $error("charging result with outputs active");

    // an empty input register always takes a request
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> o_in_ready)
        else $error("input stage empty but not ready");

    // a stalled result holds the mode state
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_motor) && $stable(r_level))
        else $error("state moved while result stalled");

endmodule

`default_nettype wire

// File: design/tlsp_cfg_regs.sv
`default_nettype none

module tlsp_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [tlsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [tlsp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output tlsp_pkg::t_cfg                        o_cfg
);

    tlsp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ticks <= tlsp_pkg::LONG_PRESS_RST;
            r_cfg.short_min_ticks  <= tlsp_pkg::SHORT_MIN_RST;
            r_cfg.motor_mode_count <= tlsp_pkg::MOTOR_COUNT_RST;
            r_cfg.heat_mode_count  <= tlsp_pkg::HEAT_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlsp_pkg::CFG_LONG_PRESS:  r_cfg.long_press_ticks <= i_cfg_data;
                tlsp_pkg::CFG_SHORT_MIN:   r_cfg.short_min_ticks  <= i_cfg_data[6:0];
                tlsp_pkg::CFG_MOTOR_COUNT: r_cfg.motor_mode_count <= i_cfg_data[3:0];
                tlsp_pkg::CFG_HEAT_COUNT:  r_cfg.heat_mode_count  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/tlsp_key_unit.sv
`default_nettype none

module tlsp_key_unit #(
    parameter int unsigned COUNT_WIDTH = tlsp_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,       // request moves to the result stage
    input  wire logic         i_clear,      // charger present
    input  wire logic         i_tick,
    input  wire logic         i_level,      // 0 = pressed
    input  wire logic [7:0]   i_long_ticks,
    input  wire logic [6:0]   i_short_ticks,
    output tlsp_pkg::t_key_evt o_evt
);

    localparam logic [COUNT_WIDTH-1:0] SAT   = COUNT_WIDTH'(tlsp_pkg::HOLD_SAT);
    localparam logic [COUNT_WIDTH-1:0] LATCH = COUNT_WIDTH'(tlsp_pkg::HOLD_LATCH);
    localparam logic [COUNT_WIDTH-1:0] LLIM  = COUNT_WIDTH'(tlsp_pkg::LONG_LIMIT);
    localparam logic [COUNT_WIDTH-1:0] SLIM  = COUNT_WIDTH'(tlsp_pkg::SHORT_LIMIT);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   sample;
    logic                   long_hit;
    logic                   short_hit;

    assign sample    = i_tick && !i_clear;
    // saturating increment, below the saturation point no wrap can occur
    assign count_inc = (r_count < SAT) ? r_count + COUNT_WIDTH'(1) : r_count;
    assign long_hit  = (count_inc > COUNT_WIDTH'(i_long_ticks)) && (count_inc < LLIM);
    assign short_hit = (r_count > COUNT_WIDTH'(i_short_ticks)) && (r_count < SLIM);

    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_tick) begin
            if (!i_level) begin
                n_count = long_hit ? LATCH : count_inc;
            end else begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_step) begin
            r_count <= n_count;
        end
    end

    // long press first, short press second
    assign o_evt = {sample && !i_level && long_hit, sample && i_level && short_hit};

endmodule

`default_nettype wire

// File: verif/testbench.sv
module testbench;

    localparam int unsigned CFG_IW = tlsp_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DW = tlsp_pkg::CFG_DATA_W;

    // One scan request as it travels on the request channel
    typedef struct packed {
        logic tick;
        logic key1;
        logic key2;
        logic charger;
    } t_scan_req;

    // One panel result, fields in port order
    typedef struct packed {
        logic       working;
        logic [3:0] motor_mode;
        logic       motor_refresh;
        logic       heating;
        logic [1:0] heat_mode;
        logic       heat_timer_clear;
        logic       charging;
        logic       timers_clear;
    } t_panel;

    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_cfg_we           = 1'b0;
    logic [CFG_IW-1:0]    i_cfg_idx          = tlsp_pkg::CFG_LONG_PRESS;
    logic [CFG_DW-1:0]    i_cfg_data         = '0;
    logic                 i_in_valid         = 1'b0;
    logic                 i_scan_tick        = 1'b0;
    logic                 i_key1_level       = 1'b1;
    logic                 i_key2_level       = 1'b1;
    logic                 i_charger_present  = 1'b0;
    logic                 i_out_ready        = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_working;
    logic [3:0]           o_motor_mode;
    logic                 o_motor_refresh;
    logic                 o_heating;
    logic [1:0]           o_heat_mode;
    logic                 o_heat_timer_clear;
    logic                 o_charging;
    logic                 o_timers_clear;

    two_key_long_short_press_mode_control dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_scan_tick        (i_scan_tick),
        .i_key1_level       (i_key1_level),
        .i_key2_level       (i_key2_level),
        .i_charger_present  (i_charger_present),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_working          (o_working),
        .o_motor_mode       (o_motor_mode),
        .o_motor_refresh    (o_motor_refresh),
        .o_heating          (o_heating),
        .o_heat_mode        (o_heat_mode),
        .o_heat_timer_clear (o_heat_timer_clear),
        .o_charging         (o_charging),
        .o_timers_clear     (o_timers_clear)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Requests waiting to go out, and panels owed by requests already accepted
    t_scan_req scan_backlog [$];
    t_panel    pending_panels [$];
    t_scan_req on_wire;
    t_panel    seen_panel;
    t_panel    due_panel;

    // Shadow of the block: register settings and control state
    tlsp_pkg::t_cfg cfg = {tlsp_pkg::LONG_PRESS_RST, tlsp_pkg::SHORT_MIN_RST,
                           tlsp_pkg::MOTOR_COUNT_RST, tlsp_pkg::HEAT_COUNT_RST};
    logic [7:0] sh_k1_hold   = '0;
    logic [7:0] sh_k2_hold   = '0;
    logic       sh_work      = 1'b0;
    logic       sh_heat      = 1'b0;
    logic [3:0] sh_motor     = '0;
    logic [1:0] sh_heat_lvl  = 2'd1;
    logic       sh_charge    = 1'b0;

    // Press generator state per key: ticks still held down, ticks still up
    int hold_left [2] = '{0, 0};
    int rest_left [2] = '{0, 0};

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int tx_gap = 0;
    int rx_hold = 0;
    bit long_hold_done = 1'b0;

    int mismatches = 0;
    int scans_sent = 0;
    int panels_seen = 0;
    int long_presses = 0;
    int short_steps = 0;
    int charge_scans = 0;
    int saturations = 0;

    // Register settings per random phase; the last one runs without idling
    int set_long  [6] = '{1, 6, 20, 255, 200, 4};
    int set_short [6] = '{0, 2, 5, 127, 3, 1};
    int set_motor [6] = '{15, 0, 1, 15, 7, 5};
    int set_heat  [6] = '{3, 0, 1, 3, 2, 3};
    int set_tx    [6] = '{0, 25, 40, 15, 30, 0};
    int set_rx    [6] = '{30, 0, 40, 20, 15, 0};

    // Advance a held key's counter; bit 8 flags a long press
    function automatic logic [8:0] hold_advance(input logic [7:0] c);
        logic [7:0] n;
        n = (c < tlsp_pkg::HOLD_SAT) ? c + 8'd1 : c;
        if (n > cfg.long_press_ticks && n < tlsp_pkg::LONG_LIMIT)
            return {1'b1, 8'(tlsp_pkg::HOLD_LATCH)};
        return {1'b0, n};
    endfunction

    // Compute the panel owed for one accepted scan request
    task automatic advance_panel(input t_scan_req r);
        t_panel     p;
        logic [8:0] hs;
        p = '0;
        if (r.charger) begin
            sh_charge = 1'b1;
            sh_work   = 1'b0;
            sh_heat   = 1'b0;
            sh_motor  = '0;
            sh_k1_hold = '0;
            sh_k2_hold = '0;
            p.motor_refresh = 1'b1;
            p.timers_clear  = 1'b1;
            charge_scans++;
        end else begin
            sh_charge = 1'b0;
            if (r.tick) begin
                // key 1 first: work toggle on long, motor step on short
                if (!r.key1) begin
                    hs = hold_advance(sh_k1_hold);
                    sh_k1_hold = hs[7:0];
                    if (hs[7:0] == 8'(tlsp_pkg::HOLD_SAT)) saturations++;
                    if (hs[8]) begin
                        if (sh_work) begin
                            sh_work  = 1'b0;
                            sh_heat  = 1'b0;
                            sh_motor = '0;
                        end else begin
                            sh_work  = 1'b1;
                            sh_motor = 4'd1;
                        end
                        p.motor_refresh = 1'b1;
                        long_presses++;
                    end
                end else begin
                    if (sh_k1_hold > cfg.short_min_ticks
                            && sh_k1_hold < tlsp_pkg::SHORT_LIMIT && sh_work) begin
                        sh_motor = (sh_motor < cfg.motor_mode_count) ? sh_motor + 4'd1
                                                                     : 4'd1;
                        p.motor_refresh = 1'b1;
                        short_steps++;
                    end
                    sh_k1_hold = '0;
                end
                // key 2: heat toggle on long, heat level step on short
                if (!r.key2) begin
                    hs = hold_advance(sh_k2_hold);
                    sh_k2_hold = hs[7:0];
                    if (hs[7:0] == 8'(tlsp_pkg::HOLD_SAT)) saturations++;
                    if (hs[8]) begin
                        if (sh_heat) begin
                            sh_heat = 1'b0;
                        end else begin
                            sh_heat     = 1'b1;
                            sh_heat_lvl = 2'd1;
                        end
                        p.heat_timer_clear = 1'b1;
                        long_presses++;
                    end
                end else begin
                    if (sh_k2_hold > cfg.short_min_ticks
                            && sh_k2_hold < tlsp_pkg::SHORT_LIMIT && sh_heat) begin
                        sh_heat_lvl = (sh_heat_lvl >= cfg.heat_mode_count) ? 2'd1
                                                                         : sh_heat_lvl + 2'd1;
                        short_steps++;
                    end
                    sh_k2_hold = '0;
                end
            end
        end
        p.working   = sh_work;
        p.motor_mode = sh_motor;
        p.heating   = sh_heat;
        p.heat_mode = sh_heat_lvl;
        p.charging  = sh_charge;
        pending_panels.push_back(p);
    endtask

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Driver: present backlog requests, hold each until taken, idle in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                advance_panel(on_wire);
                scans_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (scan_backlog.size() != 0 && tx_idle_pct != 0
                             && $urandom_range(99) < tx_idle_pct) begin
                    tx_gap = $urandom_range(10);
                    i_in_valid <= 1'b0;
                end else if (scan_backlog.size() != 0) begin
                    on_wire = scan_backlog.pop_front();
                    i_in_valid        <= 1'b1;
                    i_scan_tick       <= on_wire.tick;
                    i_key1_level      <= on_wire.key1;
                    i_key2_level      <= on_wire.key2;
                    i_charger_present <= on_wire.charger;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken panel against the oldest one owed, stall in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                panels_seen++;
                seen_panel = {o_working, o_motor_mode, o_motor_refresh, o_heating,
                              o_heat_mode, o_heat_timer_clear, o_charging, o_timers_clear};
                if (pending_panels.size() == 0) begin
                    $error("result taken with no request outstanding");
                    mismatches++;
                end else begin
                    due_panel = pending_panels.pop_front();
                    check_field("working", 4'(due_panel.working), 4'(seen_panel.working));
                    check_field("motor_mode", due_panel.motor_mode, seen_panel.motor_mode);
                    check_field("motor_refresh", 4'(due_panel.motor_refresh),
                                4'(seen_panel.motor_refresh));
                    check_field("heating", 4'(due_panel.heating), 4'(seen_panel.heating));
                    check_field("heat_mode", 4'(due_panel.heat_mode),
                                4'(seen_panel.heat_mode));
                    check_field("heat_timer_clear", 4'(due_panel.heat_timer_clear),
                                4'(seen_panel.heat_timer_clear));
                    check_field("charging", 4'(due_panel.charging),
                                4'(seen_panel.charging));
                    check_field("timers_clear", 4'(due_panel.timers_clear),
                                4'(seen_panel.timers_clear));
                end
            end
            if (rx_hold != 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if (!long_hold_done && panels_seen >= 500) begin
                // hold off long enough for the block to back up onto its input
                long_hold_done = 1'b1;
                rx_hold = 79;
                i_out_ready <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
                rx_hold = $urandom_range(10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IW-1:0] idx,
                             input logic [CFG_DW-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tlsp_pkg::CFG_LONG_PRESS:  cfg.long_press_ticks = data;
            tlsp_pkg::CFG_SHORT_MIN:   cfg.short_min_ticks  = data[6:0];
            tlsp_pkg::CFG_MOTOR_COUNT: cfg.motor_mode_count = data[3:0];
            tlsp_pkg::CFG_HEAT_COUNT:  cfg.heat_mode_count  = data[1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input int long_ticks, input int short_ticks,
                            input int motor_count, input int heat_count);
        write_reg(tlsp_pkg::CFG_LONG_PRESS, CFG_DW'(long_ticks));
        write_reg(tlsp_pkg::CFG_SHORT_MIN, CFG_DW'(short_ticks));
        write_reg(tlsp_pkg::CFG_MOTOR_COUNT, CFG_DW'(motor_count));
        write_reg(tlsp_pkg::CFG_HEAT_COUNT, CFG_DW'(heat_count));
    endtask

    // Wait until every request is out and every owed panel has come back
    task automatic drain();
        while (scan_backlog.size() != 0 || i_in_valid || pending_panels.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_scan(input logic tick, input logic k1, input logic k2,
                              input logic chg, input int reps);
        t_scan_req r;
        r = {tick, k1, k2, chg};
        repeat (reps) scan_backlog.push_back(r);
    endtask

    // Pick a hold length: mostly short presses, some too short, some long,
    // a few long enough to cross the short limit or saturate
    function automatic int press_len();
        int pick;
        int s;
        int l;
        pick = $urandom_range(99);
        s = cfg.short_min_ticks;
        l = cfg.long_press_ticks;
        if (pick < 55) return $urandom_range(s + 1, s + 6);
        if (pick < 70) return (s == 0) ? 1 : $urandom_range(1, s);
        if (pick < 97) return $urandom_range(l + 1, l + 5);
        return $urandom_range(198, 262);
    endfunction

    function automatic logic next_level(input int k, input logic tick);
        if (hold_left[k] == 0 && rest_left[k] == 0) begin
            hold_left[k] = press_len();
            rest_left[k] = $urandom_range(1, 4);
        end
        if (hold_left[k] != 0) begin
            if (tick) hold_left[k]--;
            return 1'b0;
        end
        if (tick) rest_left[k]--;
        return 1'b1;
    endfunction

    // Well-formed press sequences on both keys, with some noise and charger hits
    task automatic queue_random(input int count);
        t_scan_req r;
        for (int i = 0; i < count; i++) begin
            r.tick    = ($urandom_range(99) >= 20);
            r.charger = ($urandom_range(999) < 8);
            r.key1    = next_level(0, r.tick && !r.charger);
            r.key2    = next_level(1, r.tick && !r.charger);
            if ($urandom_range(99) < 6) begin
                r.tick = 1'($urandom);
                r.key1 = 1'($urandom);
                r.key2 = 1'($urandom);
            end
            scan_backlog.push_back(r);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under a small long threshold so long presses come quickly
        set_regs(3, 1, 2, 2);
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        @(negedge i_clk);
        queue_scan(1, 0, 0, 1, 1);  // tick while charging: dropped
        queue_scan(1, 1, 1, 0, 1);
        queue_scan(0, 0, 0, 0, 1);  // keys down without a tick: not sampled
        queue_scan(1, 0, 1, 0, 5);  // key 1 long: work on, counter latched
        queue_scan(1, 1, 1, 0, 1);  // release from the latch is never short
        queue_scan(1, 0, 1, 0, 2);  // short: motor step
        queue_scan(1, 1, 1, 0, 1);
        queue_scan(1, 0, 1, 0, 2);  // short: motor wraps to one
        queue_scan(1, 1, 1, 0, 1);
        queue_scan(1, 0, 1, 0, 1);  // too short to count
        queue_scan(1, 1, 1, 0, 1);
        queue_scan(1, 1, 0, 0, 4);  // key 2 long: heat on, timer clear
        queue_scan(1, 1, 1, 0, 1);
        queue_scan(1, 1, 0, 0, 2);  // short: heat level step
        queue_scan(1, 1, 1, 0, 1);
        queue_scan(1, 0, 0, 0, 4);  // both long in the same tick
        queue_scan(0, 1, 1, 1, 1);  // charger without a tick, heat level kept
        drain();

        for (int p = 0; p < 6; p++) begin
            set_regs(set_long[p], set_short[p], set_motor[p], set_heat[p]);
            tx_idle_pct = set_tx[p];
            rx_idle_pct = set_rx[p];
            @(negedge i_clk);
            if (set_long[p] >= tlsp_pkg::LONG_LIMIT) begin
                // threshold out of reach: hold both keys into saturation
                queue_scan(1, 0, 0, 0, 262);
                queue_scan(1, 1, 1, 0, 1);
            end
            queue_random(150);
            drain();
        end

        $display("Covered %0d scan requests and %0d results over %0d register settings.",
                 scans_sent, panels_seen, 7);
        $display("Saw %0d long presses, %0d short steps, %0d charger requests,",
                 long_presses, short_steps, charge_scans);
        $display("and %0d saturated hold ticks.", saturations);
        if (mismatches == 0 && pending_panels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
